FILE: rtl/core/ccr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_pkg: shared definitions for the colour ratio classifier
// Field widths, register layout, result struct and the digit split of a code.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int ENTRY_COUNT_DEF = 6;
  localparam int SAMPLE_BITS_DEF = 20;

  localparam int CODE_BITS      = 7;
  localparam int DIGIT_BITS     = 4;
  localparam int REG_BITS       = 21;
  localparam int REG_COUNT      = 6;
  localparam int CFG_INDEX_BITS = 3;
  localparam int INDEX_BITS     = 3;

  localparam int RED_LSB   = 0;
  localparam int GREEN_LSB = 7;
  localparam int BLUE_LSB  = 14;

  localparam int M_DATA_BITS   = 8;
  localparam int M_FOUND_BIT   = 0;
  localparam int M_INDEX_LSB   = 1;
  localparam int M_CZERO_BIT   = 4;

  typedef logic [CODE_BITS-1:0]  code_t;
  typedef logic [DIGIT_BITS-1:0] digit_t;
  typedef logic [REG_BITS-1:0]   entry_t;

  typedef struct packed {
    logic                  found;
    logic [INDEX_BITS-1:0] index;
  } match_res_t;

  // Tens digit by reciprocal multiplication, exact for every 7-bit code.
  function automatic digit_t code_tens(input code_t code);
    logic [14:0] prod;
    begin
      prod = 15'(code) * 15'd205;
      return prod[14:11];
    end
  endfunction

  function automatic digit_t code_ones(input code_t code);
    digit_t tens;
    code_t  times_ten;
    begin
      tens      = code_tens(code);
      times_ten = CODE_BITS'({tens, 3'b000}) + CODE_BITS'({tens, 1'b0});
      return DIGIT_BITS'(code - times_ten);
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ccr_div_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_div_lane: one restoring divider lane, one bit per cycle while step is high
// Loads a dividend and divisor, then produces one quotient bit per step.
// ----------------------------------------------------------------------------
module ccr_div_lane #(
  parameter int SAMPLE_BITS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   load,
  input  wire logic                   step,
  input  wire logic [SAMPLE_BITS-1:0] dividend,
  input  wire logic [SAMPLE_BITS-1:0] divisor,
  output logic      [SAMPLE_BITS-1:0] quotient
);

  logic [SAMPLE_BITS-1:0] rem;
  logic [SAMPLE_BITS-1:0] rem_next;
  logic [SAMPLE_BITS-1:0] quo;
  logic [SAMPLE_BITS-1:0] quo_next;
  logic [SAMPLE_BITS-1:0] dvs;
  logic [SAMPLE_BITS:0]   shifted;
  logic [SAMPLE_BITS:0]   diff;

  always_comb begin
    shifted = {rem, quo[SAMPLE_BITS-1]};
    diff    = shifted - {1'b0, dvs};
    if (!diff[SAMPLE_BITS]) begin
      rem_next = diff[SAMPLE_BITS-1:0];
      quo_next = {quo[SAMPLE_BITS-2:0], 1'b1};
    end else begin
      rem_next = shifted[SAMPLE_BITS-1:0];
      quo_next = {quo[SAMPLE_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (step) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule
`default_nettype wire

FILE: rtl/core/ccr_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_match: merging stage of the classifier
// Compares the three lane ratios with the digits of every reference entry
// and picks the lowest entry that matches on all channels.
// ----------------------------------------------------------------------------
module ccr_match
  import ccr_pkg::*;
#(
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic [SAMPLE_BITS-1:0] ratio_red,
  input  wire logic [SAMPLE_BITS-1:0] ratio_green,
  input  wire logic [SAMPLE_BITS-1:0] ratio_blue,
  input  wire entry_t                 entries [ENTRY_COUNT],
  output match_res_t                  res
);

  logic [ENTRY_COUNT-1:0] hit;

  function automatic logic digit_hit(input logic [SAMPLE_BITS-1:0] ratio, input code_t code);
    begin
      return (ratio == SAMPLE_BITS'(code_tens(code))) ||
             (ratio == SAMPLE_BITS'(code_ones(code)));
    end
  endfunction

  always_comb begin
    for (int e = 0; e < ENTRY_COUNT; e++) begin
      hit[e] = digit_hit(ratio_red,   entries[e][RED_LSB   +: CODE_BITS]) &&
               digit_hit(ratio_green, entries[e][GREEN_LSB +: CODE_BITS]) &&
               digit_hit(ratio_blue,  entries[e][BLUE_LSB  +: CODE_BITS]);
    end
  end

  always_comb begin
    res = '0;
    for (int e = ENTRY_COUNT - 1; e >= 0; e--) begin
      if (hit[e]) begin
        res.found = 1'b1;
        res.index = INDEX_BITS'(e);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/color_ratio_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// color_ratio_classifier: colour classification by pulse width ratios
// Divides red, green and blue widths by the clear width in three divider
// lanes and matches the ratios against the digit codes of reference entries.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         word of red, green, blue and clear widths
// m_*       out        word of match_found, color_index, clear_zero
// cfg_*     in         write of one reference entry register
//
// After acceptance the word is divided in the bit-per-cycle divider lanes,
// then done is set and the matched result waits for the output register.
// A new word is taken when the lanes hand their ratios to the output register;
// a stalled result holds up the next word only once the lanes are done.
// Reset is synchronous and clears all entries and handshake state.
// ----------------------------------------------------------------------------
module color_ratio_classifier
  import ccr_pkg::*;
#(
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int S_DATA_BITS = ((4 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // red_width, green_width, blue_width, clear_width, zero padding
  input  wire logic [S_DATA_BITS-1:0]    s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // match_found, color_index, clear_zero, zero padding
  output logic      [M_DATA_BITS-1:0]    m_tdata,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [REG_BITS-1:0]       cfg_data
);

  localparam int CNT_BITS = $clog2(SAMPLE_BITS);

  entry_t                 entries [ENTRY_COUNT];
  logic [SAMPLE_BITS-1:0] red_width;
  logic [SAMPLE_BITS-1:0] green_width;
  logic [SAMPLE_BITS-1:0] blue_width;
  logic [SAMPLE_BITS-1:0] clear_width;
  logic [SAMPLE_BITS-1:0] ratio_red;
  logic [SAMPLE_BITS-1:0] ratio_green;
  logic [SAMPLE_BITS-1:0] ratio_blue;
  logic                   busy;
  logic                   done;
  logic                   czero;
  logic [CNT_BITS-1:0]    cnt;
  logic                   accept;
  logic                   handoff;
  logic                   last_step;
  match_res_t             res;
  logic                   found;
  logic [M_DATA_BITS-1:0] m_word;

  assign red_width   = s_tdata[0 * SAMPLE_BITS +: SAMPLE_BITS];
  assign green_width = s_tdata[1 * SAMPLE_BITS +: SAMPLE_BITS];
  assign blue_width  = s_tdata[2 * SAMPLE_BITS +: SAMPLE_BITS];
  assign clear_width = s_tdata[3 * SAMPLE_BITS +: SAMPLE_BITS];

  assign handoff   = done && (!m_tvalid || m_tready);
  assign s_tready  = !busy && (!done || handoff);
  assign accept    = s_tvalid && s_tready;
  assign last_step = busy && (cnt == '0);

  for (genvar e = 0; e < ENTRY_COUNT; e++) begin : g_entry
    if (e < REG_COUNT) begin : g_reg
      always_ff @(posedge clk) begin
        if (rst) begin
          entries[e] <= '0;
        end else if (cfg_we && cfg_index == CFG_INDEX_BITS'(e)) begin
          entries[e] <= cfg_data;
        end
      end
    end else begin : g_fixed
      assign entries[e] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(SAMPLE_BITS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (last_step) begin
          busy <= 1'b0;
        end
      end
      if (last_step) begin
        done <= 1'b1;
      end else if (handoff) begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      czero <= (clear_width == '0);
    end
  end

  ccr_div_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_red (
    .clk      (clk),
    .load     (accept),
    .step     (busy),
    .dividend (red_width),
    .divisor  (clear_width),
    .quotient (ratio_red)
  );

  ccr_div_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_green (
    .clk      (clk),
    .load     (accept),
    .step     (busy),
    .dividend (green_width),
    .divisor  (clear_width),
    .quotient (ratio_green)
  );

  ccr_div_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_blue (
    .clk      (clk),
    .load     (accept),
    .step     (busy),
    .dividend (blue_width),
    .divisor  (clear_width),
    .quotient (ratio_blue)
  );

  ccr_match #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_match (
    .ratio_red   (ratio_red),
    .ratio_green (ratio_green),
    .ratio_blue  (ratio_blue),
    .entries     (entries),
    .res         (res)
  );

  assign found = res.found && !czero;

  always_comb begin
    m_word                            = '0;
    m_word[M_FOUND_BIT]               = found;
    m_word[M_INDEX_LSB +: INDEX_BITS] = found ? res.index : '0;
    m_word[M_CZERO_BIT]               = czero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (handoff) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (handoff) begin
      m_tdata <= m_word;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ccr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccr_checker: port-level checks for the colour ratio classifier
// Watches the result channel for stalls and consistency of the result word.
// ----------------------------------------------------------------------------
module ccr_checker
  import ccr_pkg::*;
#(
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   m_tvalid,
  input wire logic                   m_tready,
  input wire logic [M_DATA_BITS-1:0] m_tdata
);

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result word changed while stalled.");

  a_zero_no_match : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[M_CZERO_BIT] |-> !m_tdata[M_FOUND_BIT])
    else $error("Match reported with a zero clear width.");

  a_miss_index : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[M_FOUND_BIT] |-> m_tdata[M_INDEX_LSB +: INDEX_BITS] == '0)
    else $error("Non-zero index without a match.");

  a_index_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[M_FOUND_BIT] |->
      32'(m_tdata[M_INDEX_LSB +: INDEX_BITS]) < ENTRY_COUNT)
    else $error("Matched index beyond the last entry.");

endmodule

bind color_ratio_classifier ccr_checker #(.ENTRY_COUNT(ENTRY_COUNT)) u_ccr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
